@@ rtl/rx_buffer_ring_dispatch_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the receive buffer ring dispatcher
// Shared property forms; clock and reset are the names used in the RTL.
// ----------------------------------------------------------------------------
`ifndef RX_BUFFER_RING_DISPATCH_ASSERT_SVH
`define RX_BUFFER_RING_DISPATCH_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define RXBRD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RXBRD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/rxbrd_pkg.sv @@
// ----------------------------------------------------------------------------
// rxbrd_pkg
// Widths, codes and types shared by the receive buffer ring dispatcher.
// ----------------------------------------------------------------------------
package rxbrd_pkg;

   // default sizing
   localparam int RING_DEPTH_DEF = 256;
   localparam int NIC_MAX_DEF    = 8;
   localparam int BUF_LEN_DEF    = 1600;

   // field widths
   localparam int REQ_W  = 2;
   localparam int ADDR_W = 40;
   localparam int TAG_W  = 16;
   localparam int LEN_W  = 16;
   localparam int SRC_W  = 5;
   localparam int NET_W  = 8;
   localparam int MASK_W = 32;
   localparam int NNET_W = 9;
   localparam int STAT_W = 3;
   localparam int OLEN_W = 11;
   localparam int OIDX_W = 3;

   // request type codes on the input channel
   localparam logic [REQ_W-1:0] REQ_POST  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_COMPL = 2'd1;
   localparam logic [REQ_W-1:0] REQ_ADD   = 2'd2;
   localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

   // classified command kinds in the queue
   localparam logic [1:0] CMD_NOP   = 2'd0;
   localparam logic [1:0] CMD_POST  = 2'd1;
   localparam logic [1:0] CMD_COMPL = 2'd2;
   localparam logic [1:0] CMD_ADD   = 2'd3;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
   localparam logic [STAT_W-1:0] STAT_RING_FULL  = 3'd1;
   localparam logic [STAT_W-1:0] STAT_RING_EMPTY = 3'd2;
   localparam logic [STAT_W-1:0] STAT_MISMATCH   = 3'd3;
   localparam logic [STAT_W-1:0] STAT_NO_NIC     = 3'd4;
   localparam logic [STAT_W-1:0] STAT_TABLE_FULL = 3'd5;

   // net id that accepts any network
   localparam logic [NNET_W-1:0] WILDCARD_NET = 9'h1FF;

   // one classified command
   typedef struct packed {
      logic [1:0]        kind;
      logic [ADDR_W-1:0] addr;
      logic [TAG_W-1:0]  tag;
      logic [LEN_W-1:0]  cap_len;
      logic [SRC_W-1:0]  src;
      logic [NET_W-1:0]  pnet;
      logic [MASK_W-1:0] mask;
      logic [NNET_W-1:0] nnet;
      logic              wild;
   } cmd_type;

   // head of the command queue as seen by the execute side
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_head_type;

endpackage

@@ rtl/rxbrd_ifs.sv @@
// ----------------------------------------------------------------------------
// rxbrd_req_if / rxbrd_rsp_if
// Valid/ready channels for requests and results of the ring dispatcher.
// ----------------------------------------------------------------------------
interface rxbrd_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [rxbrd_pkg::REQ_W-1:0]           req_type;
   logic [rxbrd_pkg::ADDR_W-1:0]          buf_addr;
   logic [rxbrd_pkg::TAG_W-1:0]           buf_tag;
   logic [rxbrd_pkg::LEN_W-1:0]           pkt_len;
   logic [rxbrd_pkg::SRC_W-1:0]           src_id;
   logic [rxbrd_pkg::NET_W-1:0]           pkt_net_id;
   logic [rxbrd_pkg::MASK_W-1:0]          nic_src_mask;
   logic signed [rxbrd_pkg::NNET_W-1:0]   nic_net_id;

   modport source (output valid, req_type, buf_addr, buf_tag, pkt_len, src_id,
                   pkt_net_id, nic_src_mask, nic_net_id, input ready);
   modport sink   (input valid, req_type, buf_addr, buf_tag, pkt_len, src_id,
                   pkt_net_id, nic_src_mask, nic_net_id, output ready);
endinterface

interface rxbrd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rxbrd_pkg::STAT_W-1:0]  status;
   logic [rxbrd_pkg::TAG_W-1:0]   out_buf_tag;
   logic [rxbrd_pkg::OLEN_W-1:0]  out_len;
   logic [rxbrd_pkg::OIDX_W-1:0]  nic_index;

   modport source (output valid, status, out_buf_tag, out_len, nic_index, input ready);
   modport sink   (input valid, status, out_buf_tag, out_len, nic_index, output ready);
endinterface

@@ rtl/rx_buffer_ring_dispatch.sv @@
// ----------------------------------------------------------------------------
// rx_buffer_ring_dispatch
// Receive buffer ring with completion classifier. Requests enter a two-entry
// command queue and are executed one at a time by the back end, which owns
// the buffer ring memory and the interface table; one result beat comes out
// for every request beat, in order. A post, an add, an unused request type
// or a completion on an empty ring is done in the idle state; a completion
// that pops the ring moves on to the lookup state, after the registered read
// of the ring memory, for the address compare and interface priority match.
// The result register and the queue let new requests be taken while a result
// waits on the output. Ring entries and interface slots are not cleared by
// reset and need no clearing pass; only entries that have been written are
// ever read.
// ----------------------------------------------------------------------------
`include "rx_buffer_ring_dispatch_assert.svh"

module rx_buffer_ring_dispatch #(
   parameter int RING_DEPTH = rxbrd_pkg::RING_DEPTH_DEF,
   parameter int NIC_MAX    = rxbrd_pkg::NIC_MAX_DEF,
   parameter int BUF_LEN    = rxbrd_pkg::BUF_LEN_DEF
) (
   input logic         clock,
   input logic         reset,
   rxbrd_req_if.sink   req_bus,
   rxbrd_rsp_if.source rsp_bus
);

   rxbrd_pkg::q_head_type head;
   logic                  head_pop;

   // accept and classify
   rxbrd_front #(
      .BUF_LEN (BUF_LEN)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .head     (head),
      .head_pop (head_pop)
   );

   // execute
   rxbrd_back #(
      .RING_DEPTH (RING_DEPTH),
      .NIC_MAX    (NIC_MAX)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .head_pop (head_pop),
      .rsp_bus  (rsp_bus)
   );

   // checks
   `RXBRD_ASSERT_SAME(a_pop_needs_cmd, head_pop, head.valid, "pop from empty command queue")
   `RXBRD_ASSERT_NEXT(a_nop_result, head_pop && (head.cmd.kind == rxbrd_pkg::CMD_NOP), rsp_bus.valid && (rsp_bus.status == rxbrd_pkg::STAT_OK), "unused request gave no ok beat")
   `RXBRD_ASSERT_NEXT(a_add_result, head_pop && (head.cmd.kind == rxbrd_pkg::CMD_ADD), rsp_bus.valid && ((rsp_bus.status == rxbrd_pkg::STAT_OK) || (rsp_bus.status == rxbrd_pkg::STAT_TABLE_FULL)), "add gave a bad result beat")
   `RXBRD_ASSERT_NEXT(a_post_result, head_pop && (head.cmd.kind == rxbrd_pkg::CMD_POST), rsp_bus.valid && (rsp_bus.out_buf_tag == '0) && ((rsp_bus.status == rxbrd_pkg::STAT_OK) || (rsp_bus.status == rxbrd_pkg::STAT_RING_FULL)), "post gave a bad result beat")

endmodule

@@ rtl/rxbrd_front.sv @@
// ----------------------------------------------------------------------------
// rxbrd_front
// Accepts request beats, classifies them, caps the length and flags wildcard
// net ids, and holds them in a two-entry command queue.
// ----------------------------------------------------------------------------
module rxbrd_front #(
   parameter int BUF_LEN = rxbrd_pkg::BUF_LEN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   rxbrd_req_if.sink             req_bus,
   output rxbrd_pkg::q_head_type head,
   input  logic                  head_pop
);

   localparam int                       QD      = 2;
   localparam logic [1:0]               Q_FULL  = 2'd2;
   localparam logic [rxbrd_pkg::LEN_W-1:0] CAP  = rxbrd_pkg::LEN_W'(BUF_LEN);

   rxbrd_pkg::cmd_type slot_ff [QD];
   rxbrd_pkg::cmd_type new_cmd;
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic               push;

   // classify the incoming beat
   always_comb begin
      new_cmd.addr    = req_bus.buf_addr;
      new_cmd.tag     = req_bus.buf_tag;
      new_cmd.cap_len = (req_bus.pkt_len < CAP) ? req_bus.pkt_len : CAP;
      new_cmd.src     = req_bus.src_id;
      new_cmd.pnet    = req_bus.pkt_net_id;
      new_cmd.mask    = req_bus.nic_src_mask;
      new_cmd.nnet    = req_bus.nic_net_id;
      new_cmd.wild    = (req_bus.nic_net_id == rxbrd_pkg::WILDCARD_NET);
      unique case (req_bus.req_type)
         rxbrd_pkg::REQ_POST:  new_cmd.kind = rxbrd_pkg::CMD_POST;
         rxbrd_pkg::REQ_COMPL: new_cmd.kind = rxbrd_pkg::CMD_COMPL;
         rxbrd_pkg::REQ_ADD:   new_cmd.kind = rxbrd_pkg::CMD_ADD;
         rxbrd_pkg::REQ_NONE:  new_cmd.kind = rxbrd_pkg::CMD_NOP;
         default:              new_cmd.kind = rxbrd_pkg::CMD_NOP;
      endcase
   end

   // queue control
   assign req_bus.ready = (cnt_ff != Q_FULL);
   assign push          = req_bus.valid && req_bus.ready;

   always_comb begin
      wr_ptr_in = push     ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = head_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, head_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   assign head.valid = (cnt_ff != 2'd0);
   assign head.cmd   = slot_ff[rd_ptr_ff];

endmodule

@@ rtl/rxbrd_back.sv @@
// ----------------------------------------------------------------------------
// rxbrd_back
// Executes queued commands: buffer ring with registered-read memory, the
// interface table with its priority match, and the result register.
// ----------------------------------------------------------------------------
module rxbrd_back #(
   parameter int RING_DEPTH = rxbrd_pkg::RING_DEPTH_DEF,
   parameter int NIC_MAX    = rxbrd_pkg::NIC_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rxbrd_pkg::q_head_type head,
   output logic                  head_pop,
   rxbrd_rsp_if.source           rsp_bus
);

   localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int IW = (NIC_MAX > 1) ? $clog2(NIC_MAX) : 1;
   localparam int CW = $clog2(NIC_MAX + 1);
   localparam int MW = rxbrd_pkg::ADDR_W + rxbrd_pkg::TAG_W;
   localparam logic [AW-1:0] SLOT_LAST = AW'(RING_DEPTH - 1);
   localparam logic [CW-1:0] NIC_LIMIT = CW'(NIC_MAX);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_LOOKUP = 1'b1;

   // ring memory and read register
   logic [MW-1:0] ring_mem [RING_DEPTH];
   logic [MW-1:0] mem_q_ff;
   logic          mem_wr, mem_rd;

   // pointers and control
   logic [AW-1:0] wr_slot_ff, wr_slot_in, rd_slot_ff, rd_slot_in;
   logic          wr_wrap_ff, wr_wrap_in, rd_wrap_ff, rd_wrap_in;
   logic [CW-1:0] nic_count_ff, nic_count_in;
   logic          state_ff, state_in;
   logic          ring_empty, ring_full, out_free, tbl_wr;

   // interface table
   logic [rxbrd_pkg::MASK_W-1:0] mask_ff  [NIC_MAX];
   logic [rxbrd_pkg::NNET_W-1:0] netid_ff [NIC_MAX];
   logic                         wild_ff  [NIC_MAX];

   // pending completion and result register
   rxbrd_pkg::cmd_type           pend_ff, pend_in;
   logic                         rsp_valid_ff, rsp_valid_in, load;
   logic [rxbrd_pkg::STAT_W-1:0] stat_ff, stat_in;
   logic [rxbrd_pkg::TAG_W-1:0]  tag_ff, tag_in;
   logic [rxbrd_pkg::OLEN_W-1:0] len_ff, len_in;
   logic [rxbrd_pkg::OIDX_W-1:0] idx_ff, idx_in;

   // match search
   logic [NIC_MAX-1:0]           hit;
   logic [IW-1:0]                hit_idx;
   logic [rxbrd_pkg::ADDR_W-1:0] mem_addr;
   logic [rxbrd_pkg::TAG_W-1:0]  mem_tag;

   assign ring_empty = (wr_slot_ff == rd_slot_ff) && (wr_wrap_ff == rd_wrap_ff);
   assign ring_full  = (wr_slot_ff == rd_slot_ff) && (wr_wrap_ff != rd_wrap_ff);
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign mem_addr   = mem_q_ff[MW-1:rxbrd_pkg::TAG_W];
   assign mem_tag    = mem_q_ff[rxbrd_pkg::TAG_W-1:0];

   // per-slot hit against the pending completion
   always_comb begin
      for (int i = 0; i < NIC_MAX; i++) begin
         hit[i] = (CW'(i) < nic_count_ff) && mask_ff[i][pend_ff.src] &&
                  (wild_ff[i] || (netid_ff[i] == {1'b0, pend_ff.pnet}));
      end
   end

   // lowest hit wins
   always_comb begin
      hit_idx = '0;
      for (int i = NIC_MAX - 1; i >= 0; i--) begin
         if (hit[i]) begin
            hit_idx = IW'(i);
         end
      end
   end

   // command sequencer
   always_comb begin
      head_pop     = 1'b0;
      state_in     = state_ff;
      pend_in      = pend_ff;
      mem_wr       = 1'b0;
      mem_rd       = 1'b0;
      tbl_wr       = 1'b0;
      wr_slot_in   = wr_slot_ff;
      wr_wrap_in   = wr_wrap_ff;
      rd_slot_in   = rd_slot_ff;
      rd_wrap_in   = rd_wrap_ff;
      nic_count_in = nic_count_ff;
      load         = 1'b0;
      stat_in      = rxbrd_pkg::STAT_OK;
      tag_in       = '0;
      len_in       = '0;
      idx_in       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid && out_free) begin
               head_pop = 1'b1;
               unique case (head.cmd.kind)
                  rxbrd_pkg::CMD_POST: begin
                     load = 1'b1;
                     if (ring_full) begin
                        stat_in = rxbrd_pkg::STAT_RING_FULL;
                     end else begin
                        mem_wr = 1'b1;
                        if (wr_slot_ff == SLOT_LAST) begin
                           wr_slot_in = '0;
                           wr_wrap_in = ~wr_wrap_ff;
                        end else begin
                           wr_slot_in = wr_slot_ff + AW'(1);
                        end
                     end
                  end
                  rxbrd_pkg::CMD_COMPL: begin
                     if (ring_empty) begin
                        load    = 1'b1;
                        stat_in = rxbrd_pkg::STAT_RING_EMPTY;
                     end else begin
                        mem_rd   = 1'b1;
                        pend_in  = head.cmd;
                        state_in = ST_LOOKUP;
                        if (rd_slot_ff == SLOT_LAST) begin
                           rd_slot_in = '0;
                           rd_wrap_in = ~rd_wrap_ff;
                        end else begin
                           rd_slot_in = rd_slot_ff + AW'(1);
                        end
                     end
                  end
                  rxbrd_pkg::CMD_ADD: begin
                     load = 1'b1;
                     if (nic_count_ff < NIC_LIMIT) begin
                        tbl_wr       = 1'b1;
                        nic_count_in = nic_count_ff + CW'(1);
                     end else begin
                        stat_in = rxbrd_pkg::STAT_TABLE_FULL;
                     end
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
               tag_in   = mem_tag;
               if (mem_addr != pend_ff.addr) begin
                  stat_in = rxbrd_pkg::STAT_MISMATCH;
               end else begin
                  len_in = pend_ff.cap_len[rxbrd_pkg::OLEN_W-1:0];
                  if (hit != '0) begin
                     idx_in = rxbrd_pkg::OIDX_W'(hit_idx);
                  end else begin
                     stat_in = rxbrd_pkg::STAT_NO_NIC;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = load ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_slot_ff   <= '0;
         wr_wrap_ff   <= 1'b0;
         rd_slot_ff   <= '0;
         rd_wrap_ff   <= 1'b0;
         nic_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_slot_ff   <= wr_slot_in;
         wr_wrap_ff   <= wr_wrap_in;
         rd_slot_ff   <= rd_slot_in;
         rd_wrap_ff   <= rd_wrap_in;
         nic_count_ff <= nic_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (load) begin
         stat_ff <= stat_in;
         tag_ff  <= tag_in;
         len_ff  <= len_in;
         idx_ff  <= idx_in;
      end
   end

   // ring memory write port
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         ring_mem[wr_slot_ff] <= {head.cmd.addr, head.cmd.tag};
      end
   end

   // ring memory read port
   always_ff @(posedge clock) begin
      if (mem_rd) begin
         mem_q_ff <= ring_mem[rd_slot_ff];
      end
   end

   // interface table write
   always_ff @(posedge clock) begin
      if (tbl_wr) begin
         mask_ff[nic_count_ff[IW-1:0]]  <= head.cmd.mask;
         netid_ff[nic_count_ff[IW-1:0]] <= head.cmd.nnet;
         wild_ff[nic_count_ff[IW-1:0]]  <= head.cmd.wild;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = stat_ff;
   assign rsp_bus.out_buf_tag = tag_ff;
   assign rsp_bus.out_len     = len_ff;
   assign rsp_bus.nic_index   = idx_ff;

endmodule
